// File: rtl/cht_pkg.sv
`timescale 1ns / 1ps

package cht_pkg;

    localparam int BUCKETS      = 10;
    localparam int POOL_NODES   = 64;

    localparam int KEY_W        = 31;
    localparam int STATUS_W     = 3;
    localparam int BUCKET_OUT_W = 4;
    localparam int POS_OUT_W    = 7;

    localparam int BUCKET_W     = $clog2(BUCKETS);
    localparam int LINK_W       = $clog2(POOL_NODES + 1);
    localparam int POOL_AW      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int POS_CNT_W    = $clog2(POOL_NODES + 2);
    localparam int POOL_DW      = KEY_W + LINK_W;

    localparam int MOD_BITS     = 4;
    localparam int MOD_STEPS    = (KEY_W + MOD_BITS - 1) / MOD_BITS;
    localparam int KEY_PAD_W    = MOD_STEPS * MOD_BITS;
    localparam int MOD_CNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

    localparam int S_TDATA_W    = ((KEY_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((STATUS_W + BUCKET_OUT_W + POS_OUT_W + 7) / 8) * 8;

    localparam logic [LINK_W-1:0]    NULL_LINK  = LINK_W'(POOL_NODES);
    localparam logic [BUCKET_W:0]    BUCKET_DIV = (BUCKET_W + 1)'(BUCKETS);
    localparam logic [MOD_CNT_W-1:0] MOD_LAST   = MOD_CNT_W'(MOD_STEPS - 1);

    typedef enum logic [0:0] {
        FUNC_INSERT = 1'b0,
        FUNC_SEARCH = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_HEAD  = 3'd0,
        STS_CHAIN = 3'd1,
        STS_FULL  = 3'd2,
        STS_FOUND = 3'd3,
        STS_MISS  = 3'd4,
        STS_EMPTY = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_DECIDE,
        S_WALK_INS,
        S_WALK_SRCH,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] rem;
    } mod_res_t;

endpackage

// File: rtl/cht_mod_unit.sv
`timescale 1ns / 1ps

module cht_mod_unit
    import cht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key_value,
    output mod_res_t         res
);

    logic [KEY_PAD_W-1:0] sh_reg;
    logic [KEY_PAD_W-1:0] sh_next;
    logic [BUCKET_W-1:0]  rem_reg;
    logic [BUCKET_W-1:0]  rem_next;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [MOD_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [BUCKET_W-1:0]  r;
    logic [BUCKET_W:0]    t;

    // one radix-16 digit of the key per cycle, restoring remainder
    always_comb
    begin
        r = rem_reg;
        t = '0;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {r, sh_reg[KEY_PAD_W-1-i]};
            if (t >= BUCKET_DIV)
            begin
                t = t - BUCKET_DIV;
            end
            r = t[BUCKET_W-1:0];
        end
    end

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = KEY_PAD_W'(key_value);
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << MOD_BITS;
            rem_next = r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MOD_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign res.done = done_reg;
    assign res.rem  = rem_reg;

endmodule

// File: rtl/cht_pool_ram.sv
`timescale 1ns / 1ps

module cht_pool_ram
#(
    parameter int DW    = 38,
    parameter int AW    = 6,
    parameter int DEPTH = 64
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/chained_hash_table.sv
`timescale 1ns / 1ps
// Hash table with separate chaining over a shared pool of chain nodes.
// Input channel s_axis: tdata carries the 31-bit key, tuser the operation
// (0 insert, 1 search). Output channel m_axis: tdata carries status in
// bits 2:0, bucket in bits 6:3 and chain position in bits 13:7.
// Exactly one result item follows each input item, in order.
// An item passes through the bucket remainder unit, which takes four key bits
// per cycle, and then, where chain nodes are visited, through a chain walk
// that is bound by one read of the node memory per cycle; the result then
// waits in the finish state until the output register is free.
// s_axis_tready is high only while the block is idle; the next item may be
// accepted from the cycle after the result is loaded into the output register.
// If the receiver stalls, the result holds in the output register and the
// block still accepts and works on one more item, then waits to hand it on.
// Reset clears the bucket map, the head links and the node count; no
// clearing pass is needed.
module chained_hash_table
    import cht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // key_value
    input  logic                 s_axis_tuser,   // func
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata    // status, bucket, chain_position
);

    state_t                state_reg;
    state_t                state_next;
    func_t                 func_reg;
    func_t                 func_next;
    logic [KEY_W-1:0]      key_reg;
    logic [KEY_W-1:0]      key_next;
    logic [BUCKET_W-1:0]   bucket_reg;
    logic [BUCKET_W-1:0]   bucket_next;
    logic [POOL_AW-1:0]    cur_reg;
    logic [POOL_AW-1:0]    cur_next;
    logic [POOL_AW-1:0]    node_reg;
    logic [POOL_AW-1:0]    node_next;
    logic [POS_CNT_W-1:0]  pos_reg;
    logic [POS_CNT_W-1:0]  pos_next;
    logic [LINK_W-1:0]     count_reg;
    logic [LINK_W-1:0]     count_next;
    status_t               res_status_reg;
    status_t               res_status_next;
    logic [POS_CNT_W-1:0]  res_pos_reg;
    logic [POS_CNT_W-1:0]  res_pos_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg;
    logic [M_TDATA_W-1:0]  m_data_next;

    logic                  used_reg      [BUCKETS];
    logic [KEY_W-1:0]      head_key_reg  [BUCKETS];
    logic [LINK_W-1:0]     head_link_reg [BUCKETS];

    logic                  head_we;
    logic                  link_we;
    logic                  pool_we;
    logic [POOL_AW-1:0]    pool_waddr;
    logic [POOL_DW-1:0]    pool_wdata;
    logic                  pool_re;
    logic [POOL_AW-1:0]    pool_raddr;
    logic [POOL_DW-1:0]    pool_rdata;

    logic                  mod_start;
    mod_res_t              mod_res;

    logic                  accept;
    logic                  out_free;
    logic                  cur_used;
    logic [KEY_W-1:0]      cur_head_key;
    logic [LINK_W-1:0]     cur_head_link;
    logic                  head_null;
    logic                  head_hit;
    logic                  pool_full;
    logic [KEY_W-1:0]      rd_key;
    logic [LINK_W-1:0]     rd_link;
    logic                  rd_null;
    logic                  rd_hit;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cur_used      = used_reg[bucket_reg];
    assign cur_head_key  = head_key_reg[bucket_reg];
    assign cur_head_link = head_link_reg[bucket_reg];
    assign head_null     = (cur_head_link == NULL_LINK);
    assign head_hit      = (cur_head_key == key_reg);
    assign pool_full     = (count_reg >= NULL_LINK);
    assign rd_key        = pool_rdata[POOL_DW-1:LINK_W];
    assign rd_link       = pool_rdata[LINK_W-1:0];
    assign rd_null       = (rd_link == NULL_LINK);
    assign rd_hit        = (rd_key == key_reg);

    cht_mod_unit u_mod
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .key_value (s_axis_tdata[KEY_W-1:0]),
        .res       (mod_res)
    );

    cht_pool_ram
    #(
        .DW    (POOL_DW),
        .AW    (POOL_AW),
        .DEPTH (POOL_NODES)
    )
    u_pool
    (
        .clk   (clk),
        .we    (pool_we),
        .waddr (pool_waddr),
        .wdata (pool_wdata),
        .re    (pool_re),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_res.done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (func_reg == FUNC_INSERT)
                begin
                    if (cur_used && !pool_full && !head_null)
                    begin
                        state_next = S_WALK_INS;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    if (cur_used && !head_hit && !head_null)
                    begin
                        state_next = S_WALK_SRCH;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_WALK_INS:
            begin
                if (rd_null)
                begin
                    state_next = S_FIN;
                end
            end
            S_WALK_SRCH:
            begin
                if (rd_hit || rd_null)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready   = (state_reg == S_IDLE);
        mod_start       = 1'b0;
        func_next       = func_reg;
        key_next        = key_reg;
        bucket_next     = bucket_reg;
        cur_next        = cur_reg;
        node_next       = node_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        head_we         = 1'b0;
        link_we         = 1'b0;
        pool_we         = 1'b0;
        pool_waddr      = node_reg;
        pool_wdata      = {key_reg, NULL_LINK};
        pool_re         = 1'b0;
        pool_raddr      = cur_head_link[POOL_AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mod_start = 1'b1;
                    func_next = func_t'(s_axis_tuser);
                    key_next  = s_axis_tdata[KEY_W-1:0];
                end
            end
            S_MOD:
            begin
                if (mod_res.done)
                begin
                    bucket_next = mod_res.rem;
                end
            end
            S_DECIDE:
            begin
                res_pos_next = '0;
                cur_next     = cur_head_link[POOL_AW-1:0];
                pos_next     = POS_CNT_W'(1);
                if (func_reg == FUNC_INSERT)
                begin
                    if (!cur_used)
                    begin
                        head_we         = 1'b1;
                        res_status_next = STS_HEAD;
                    end
                    else if (pool_full)
                    begin
                        res_status_next = STS_FULL;
                    end
                    else
                    begin
                        // allocate the next node as the new tail
                        node_next       = count_reg[POOL_AW-1:0];
                        count_next      = count_reg + 1'b1;
                        pool_we         = 1'b1;
                        pool_waddr      = count_reg[POOL_AW-1:0];
                        res_status_next = STS_CHAIN;
                        res_pos_next    = POS_CNT_W'(1);
                        if (head_null)
                        begin
                            link_we = 1'b1;
                        end
                        else
                        begin
                            pool_re = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (!cur_used)
                    begin
                        res_status_next = STS_EMPTY;
                    end
                    else if (head_hit)
                    begin
                        res_status_next = STS_FOUND;
                    end
                    else if (head_null)
                    begin
                        res_status_next = STS_MISS;
                    end
                    else
                    begin
                        pool_re = 1'b1;
                    end
                end
            end
            S_WALK_INS:
            begin
                if (rd_null)
                begin
                    // link the tail to the new node
                    pool_we         = 1'b1;
                    pool_waddr      = cur_reg;
                    pool_wdata      = {rd_key, LINK_W'(node_reg)};
                    res_status_next = STS_CHAIN;
                    res_pos_next    = pos_reg + 1'b1;
                end
                else
                begin
                    pool_re    = 1'b1;
                    pool_raddr = rd_link[POOL_AW-1:0];
                    cur_next   = rd_link[POOL_AW-1:0];
                    pos_next   = pos_reg + 1'b1;
                end
            end
            S_WALK_SRCH:
            begin
                if (rd_hit)
                begin
                    res_status_next = STS_FOUND;
                    res_pos_next    = pos_reg;
                end
                else if (rd_null)
                begin
                    res_status_next = STS_MISS;
                    res_pos_next    = '0;
                end
                else
                begin
                    pool_re    = 1'b1;
                    pool_raddr = rd_link[POOL_AW-1:0];
                    cur_next   = rd_link[POOL_AW-1:0];
                    pos_next   = pos_reg + 1'b1;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({POS_OUT_W'(res_pos_reg),
                                               BUCKET_OUT_W'(bucket_reg),
                                               res_status_reg});
                end
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        bucket_reg     <= bucket_next;
        cur_reg        <= cur_next;
        node_reg       <= node_next;
        pos_reg        <= pos_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        m_data_reg     <= m_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BUCKETS; i++)
            begin
                used_reg[i]      <= 1'b0;
                head_link_reg[i] <= NULL_LINK;
            end
        end
        else
        begin
            if (head_we)
            begin
                used_reg[bucket_reg] <= 1'b1;
            end
            if (link_we)
            begin
                head_link_reg[bucket_reg] <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            head_key_reg[bucket_reg] <= key_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NULL_LINK)
        else $error("node count beyond pool size");

    assert property (@(posedge clk) disable iff (!rst_n)
        link_we |-> (used_reg[bucket_reg] && head_null))
        else $error("head link written on an empty bucket or over a chain");

    assert property (@(posedge clk) disable iff (!rst_n)
        (pool_we && state_reg == S_DECIDE) |-> !pool_full)
        else $error("node allocated from an exhausted pool");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result item raised outside the finish state");

endmodule
